>>> design/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg: shared definitions for the range encoder
// Code register widths, renormalization limits, error codes and the
// request/response bundles of the serial divide/multiply unit.
// ----------------------------------------------------------------------------
package rce_pkg;

  // code register geometry
  localparam int CODE_W    = 32;
  localparam int TOP_SHIFT = CODE_W - 9;
  localparam int FREQ_W    = 16;
  localparam int COUNT_W   = 24;
  localparam int PEND_W    = 6;
  localparam int ERR_W     = 3;

  localparam logic [CODE_W-1:0] TOP_VAL    = CODE_W'(1) << (CODE_W - 1);
  localparam logic [CODE_W-1:0] BOTTOM_VAL = TOP_VAL >> 8;
  // below this the top byte of low is settled without a carry
  localparam logic [CODE_W-1:0] SETTLE_LIM = CODE_W'(32'hff) << TOP_SHIFT;

  // pending 0xff run limit
  localparam logic [PEND_W-1:0] MAX_PENDING = PEND_W'(48);

  // bytes added to the count on finish (final byte, trailer, header)
  localparam logic [COUNT_W-1:0] FINISH_ADD = COUNT_W'(5);

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BIG   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd3;
  localparam logic [ERR_W-1:0] ERR_OVF   = 3'd4;

  // request to the divide/multiply unit
  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] range;
    logic [FREQ_W-1:0] tot;
    logic [FREQ_W-1:0] clo;
    logic [FREQ_W-1:0] dlt;
  } dm_req_t;

  // response: part = (range / tot) * clo, prod = (range / tot) * dlt
  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] part;
    logic [CODE_W-1:0] prod;
  } dm_rsp_t;

endpackage

>>> design/rce_divmul.sv
// ----------------------------------------------------------------------------
// rce_divmul: bit-serial divide and dual multiply
// Restoring division of range by tot, one quotient bit per cycle, then two
// shift-add products of the quotient, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rce_divmul (
  input  logic             clk,
  input  logic             rst,
  input  rce_pkg::dm_req_t req,
  output rce_pkg::dm_rsp_t rsp
);

  localparam logic [1:0] DM_IDLE = 2'd0;
  localparam logic [1:0] DM_DIV  = 2'd1;
  localparam logic [1:0] DM_MUL  = 2'd2;

  logic [1:0]                     state;
  logic [4:0]                     cnt;
  logic [rce_pkg::CODE_W-1:0]     quo;
  logic [rce_pkg::FREQ_W-1:0]     rem;
  logic [rce_pkg::FREQ_W-1:0]     tot;
  logic [rce_pkg::FREQ_W-1:0]     ma;
  logic [rce_pkg::FREQ_W-1:0]     mb;
  logic [rce_pkg::CODE_W-1:0]     acc_a;
  logic [rce_pkg::CODE_W-1:0]     acc_b;
  logic                           done;

  logic [rce_pkg::FREQ_W:0]       rem_sh;
  logic                           ge;
  logic [rce_pkg::FREQ_W:0]       rem_sub;

  // one restoring step
  assign rem_sh  = {rem, quo[rce_pkg::CODE_W-1]};
  assign ge      = rem_sh >= {1'b0, tot};
  assign rem_sub = rem_sh - {1'b0, tot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DM_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        DM_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            quo   <= req.range;
            rem   <= '0;
            tot   <= req.tot;
            ma    <= req.clo;
            mb    <= req.dlt;
            cnt   <= '0;
            state <= DM_DIV;
          end
        end
        DM_DIV: begin
          rem <= ge ? rem_sub[rce_pkg::FREQ_W-1:0] : rem_sh[rce_pkg::FREQ_W-1:0];
          quo <= {quo[rce_pkg::CODE_W-2:0], ge};
          // counter wraps to zero after the last quotient bit
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            acc_a <= '0;
            acc_b <= '0;
            state <= DM_MUL;
          end
        end
        DM_MUL: begin
          // multiplier bits taken from the top down
          acc_a <= {acc_a[rce_pkg::CODE_W-2:0], 1'b0}
                   + (ma[rce_pkg::FREQ_W-1] ? quo : '0);
          acc_b <= {acc_b[rce_pkg::CODE_W-2:0], 1'b0}
                   + (mb[rce_pkg::FREQ_W-1] ? quo : '0);
          ma    <= {ma[rce_pkg::FREQ_W-2:0], 1'b0};
          mb    <= {mb[rce_pkg::FREQ_W-2:0], 1'b0};
          cnt   <= cnt + 5'd1;
          done  <= (cnt == 5'd15);
          if (cnt == 5'd15) begin
            state <= DM_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= DM_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.part = acc_a;
  assign rsp.prod = acc_b;

endmodule

>>> design/range_encoder_byte_carry_unit.sv
// ----------------------------------------------------------------------------
// range_encoder_byte_carry_unit: 32-bit byte-oriented range encoder
// Renormalizes with a held byte and a pending 0xff run for late carries,
// then narrows low and range by a bit-serial divide and multiply. A finish
// item flushes the final byte and a 3-byte count trailer, then restarts.
//
//   channel  dir  signals                      contents
//   s        in   s_tvalid s_tready            one symbol or finish item
//                 s_tdata[47:0] s_tuser[0]     see port comments
//   m        out  m_tvalid m_tready            coded bytes and error reports,
//                 m_tdata[7:0] m_tuser[3:0]    zero or more per item, m_tlast on final
//
// A symbol item passes idle, normalize, check, wait (while rce_divmul
// divides, then multiplies) and end; a bad symbol goes from check to end
// with its report. Renormalization puts out the held byte and each pending
// byte per settled byte, or adds to the pending run; an overflow is reported
// unless the symbol is bad. A stalled m_tready holds the sequencer. Reset is
// synchronous and restores header byte 0.
// ----------------------------------------------------------------------------
module range_encoder_byte_carry_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cum_low[15:0], cum_high[31:16], total[47:32]
  input  logic [0:0]  s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic [3:0]  m_tuser,   // byte_valid[0], error[3:1]
  output logic        m_tlast
);

  localparam int CB = rce_pkg::CODE_W;
  localparam int SB = rce_pkg::TOP_SHIFT;
  localparam int FW = rce_pkg::FREQ_W;
  localparam int NW = rce_pkg::COUNT_W;
  localparam int PW = rce_pkg::PEND_W;
  localparam int EW = rce_pkg::ERR_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NORM   = 4'd1;
  localparam logic [3:0] ST_HELD   = 4'd2;
  localparam logic [3:0] ST_PEND   = 4'd3;
  localparam logic [3:0] ST_NSHIFT = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_WAIT   = 4'd6;
  localparam logic [3:0] ST_FINA   = 4'd7;
  localparam logic [3:0] ST_FOUT   = 4'd8;
  localparam logic [3:0] ST_END    = 4'd9;

  logic [3:0]     state;
  logic           cmd;
  logic [FW-1:0]  clo;
  logic [FW-1:0]  chi;
  logic [FW-1:0]  tot;
  logic [CB-1:0]  low;
  logic [CB-1:0]  range;
  logic [7:0]     held;
  logic [PW-1:0]  pend;
  logic [NW-1:0]  bc;
  logic [2:0]     iter;
  logic           ovf;
  logic           carry;
  logic           ret_fin;
  logic [7:0]     fin_byte;
  logic [EW-1:0]  err;

  // result stage, one result deep, so the final result can be marked last
  logic           st_valid;
  logic [7:0]     st_byte;
  logic           st_bv;
  logic [EW-1:0]  st_err;

  logic           can_put;
  logic           put_req;
  logic [7:0]     put_byte;
  logic           put_bv;
  logic [EW-1:0]  put_err;
  logic           put_ok;
  logic           flush_req;
  logic           push;

  logic [CB-1:0]  low_sh;
  logic [CB-1:0]  range_sh;
  logic [NW-1:0]  bc_inc;
  logic [NW-1:0]  bc5;
  logic [9:0]     fin;
  logic           no_round;
  logic           bad_zero;
  logic           bad_big;
  logic           bad_empty;

  rce_pkg::dm_req_t dm_req;
  rce_pkg::dm_rsp_t dm_rsp;

  assign s_tready = (state == ST_IDLE);

  // one renormalization shift
  assign low_sh   = {1'b0, low[SB-1:0], 8'h00};
  assign range_sh = {range[CB-9:0], 8'h00};
  assign bc_inc   = bc + NW'(1);

  // final byte rounding
  assign bc5      = bc + rce_pkg::FINISH_ADD;
  assign no_round = low[SB-1:0] < bc5[NW-1:1];
  assign fin      = {1'b0, low[CB-1:SB]} + {9'd0, ~no_round};

  // symbol checks
  assign bad_zero  = (tot == '0);
  assign bad_big   = {{(CB-FW){1'b0}}, tot} > {1'b0, range[CB-1:1]};
  assign bad_empty = (chi <= clo) || (chi > tot);

  // divide/multiply unit
  assign dm_req.start = (state == ST_CHECK) && !bad_zero && !bad_big && !bad_empty;
  assign dm_req.range = range;
  assign dm_req.tot   = tot;
  assign dm_req.clo   = clo;
  assign dm_req.dlt   = chi - clo;

  rce_divmul u_divmul (
    .clk (clk),
    .rst (rst),
    .req (dm_req),
    .rsp (dm_rsp)
  );

  // result requests from the sequencer
  always_comb begin
    put_req   = 1'b0;
    put_byte  = 8'h00;
    put_bv    = 1'b1;
    put_err   = rce_pkg::ERR_OK;
    flush_req = 1'b0;
    unique case (state)
      ST_HELD: begin
        put_req  = 1'b1;
        put_byte = held + {7'd0, carry};
      end
      ST_PEND: begin
        put_req  = (pend != '0);
        put_byte = carry ? 8'h00 : 8'hff;
      end
      ST_FOUT: begin
        put_req = 1'b1;
        case (iter[1:0])
          2'd0:    put_byte = fin_byte;
          2'd1:    put_byte = bc[23:16];
          2'd2:    put_byte = bc[15:8];
          default: put_byte = bc[7:0];
        endcase
      end
      ST_END: begin
        if (err != rce_pkg::ERR_OK) begin
          put_req = 1'b1;
          put_bv  = 1'b0;
          put_err = err;
        end else begin
          flush_req = st_valid;
        end
      end
      default: ;
    endcase
  end

  assign can_put = !m_tvalid || m_tready;
  assign put_ok  = !st_valid || can_put;
  assign push    = st_valid && ((put_req && put_ok) || (flush_req && can_put));

  // stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (put_req && put_ok) begin
        st_valid <= 1'b1;
        st_byte  <= put_byte;
        st_bv    <= put_bv;
        st_err   <= put_err;
      end else if (flush_req && can_put) begin
        st_valid <= 1'b0;
      end
      if (push) begin
        m_tvalid <= 1'b1;
        m_tdata  <= st_byte;
        m_tuser  <= {st_err, st_bv};
        m_tlast  <= flush_req;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      low     <= '0;
      range   <= rce_pkg::TOP_VAL;
      held    <= '0;
      pend    <= '0;
      bc      <= '0;
      iter    <= '0;
      ovf     <= 1'b0;
      carry   <= 1'b0;
      ret_fin <= 1'b0;
      err     <= rce_pkg::ERR_OK;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser[0];
            clo   <= s_tdata[15:0];
            chi   <= s_tdata[31:16];
            tot   <= s_tdata[47:32];
            iter  <= '0;
            ovf   <= 1'b0;
            err   <= rce_pkg::ERR_OK;
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (!iter[2] && range <= rce_pkg::BOTTOM_VAL) begin
            if (low < rce_pkg::SETTLE_LIM) begin
              carry   <= 1'b0;
              ret_fin <= 1'b0;
              state   <= ST_HELD;
            end else if (low[CB-1]) begin
              carry   <= 1'b1;
              ret_fin <= 1'b0;
              state   <= ST_HELD;
            end else begin
              // undecided byte joins the pending run, or sets the overflow flag when the run is full
              if (pend < rce_pkg::MAX_PENDING) pend <= pend + PW'(1);
              else ovf <= 1'b1;
              low   <= low_sh;
              range <= range_sh;
              bc    <= bc_inc;
              iter  <= iter + 3'd1;
            end
          end else begin
            state <= cmd ? ST_FINA : ST_CHECK;
          end
        end
        ST_HELD: begin
          if (put_ok) state <= ST_PEND;
        end
        ST_PEND: begin
          if (pend == '0) begin
            if (ret_fin) begin
              iter  <= '0;
              state <= ST_FOUT;
            end else begin
              state <= ST_NSHIFT;
            end
          end else if (put_ok) begin
            pend <= pend - PW'(1);
          end
        end
        ST_NSHIFT: begin
          held  <= low[CB-2:SB];
          low   <= low_sh;
          range <= range_sh;
          bc    <= bc_inc;
          iter  <= iter + 3'd1;
          state <= ST_NORM;
        end
        ST_FINA: begin
          bc       <= bc5;
          fin_byte <= fin[7:0];
          carry    <= fin[9] | fin[8];
          ret_fin  <= 1'b1;
          state    <= ST_HELD;
        end
        ST_FOUT: begin
          if (put_ok) begin
            if (iter[1:0] == 2'd3) begin
              // restart with header byte 0
              low   <= '0;
              range <= rce_pkg::TOP_VAL;
              held  <= '0;
              pend  <= '0;
              bc    <= '0;
              err   <= ovf ? rce_pkg::ERR_OVF : rce_pkg::ERR_OK;
              state <= ST_END;
            end else begin
              iter <= iter + 3'd1;
            end
          end
        end
        ST_CHECK: begin
          if (bad_zero) begin
            err   <= rce_pkg::ERR_ZERO;
            state <= ST_END;
          end else if (bad_big) begin
            err   <= rce_pkg::ERR_BIG;
            state <= ST_END;
          end else if (bad_empty) begin
            err   <= rce_pkg::ERR_EMPTY;
            state <= ST_END;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (dm_rsp.done) begin
            low   <= low + dm_rsp.part;
            range <= (chi < tot) ? dm_rsp.prod : range - dm_rsp.part;
            err   <= ovf ? rce_pkg::ERR_OVF : rce_pkg::ERR_OK;
            state <= ST_END;
          end
        end
        ST_END: begin
          if (err != rce_pkg::ERR_OK) begin
            if (put_ok) err <= rce_pkg::ERR_OK;
          end else if (!st_valid || can_put) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> test/tb_range_encoder_byte_carry_unit.sv
// ----------------------------------------------------------------------------
// tb_range_encoder_byte_carry_unit: self-checking bench for the range encoder
// Keeps its own copy of the coder state, predicts every coded byte and error
// report of each accepted item, and checks the result stream in order.
// Directed items cover field extremes, zero totals, empty intervals, a late
// carry and a pending-run overflow. Random items follow in several idling mixes.
// ----------------------------------------------------------------------------
module tb_range_encoder_byte_carry_unit;
  import rce_pkg::*;

  localparam logic CMD_SYMBOL = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam int   MAX_RESULTS = 64;
  localparam int   CYCLE_LIMIT = 500000;
  localparam int   TAIL_CYCLES = 200;

  // one coded result
  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             last;
    logic [ERR_W-1:0] err;
  } coded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // cum_low[15:0], cum_high[31:16], total[47:32]
  logic [0:0]  s_tuser = '0;   // command[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_byte[7:0]
  logic [3:0]  m_tuser;        // byte_valid[0], error[3:1]
  logic        m_tlast;

  range_encoder_byte_carry_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Coder model state and expected byte stream
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0]    enc_low;
  logic [CODE_W-1:0]    enc_range;
  logic [7:0]           enc_held;
  logic [PEND_W-1:0]    enc_pend;
  logic [COUNT_W-1:0]   enc_count;

  coded_t item_bytes[MAX_RESULTS];
  int     item_nbytes;
  coded_t expected_bytes[$];

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int symbols_sent = 0;
  int finishes_sent = 0;
  int error_reports = 0;
  int carry_flushes = 0;
  int cycle_count = 0;

  function automatic void coder_restart();
    enc_low   = '0;
    enc_range = TOP_VAL;
    enc_held  = 8'h00;
    enc_pend  = '0;
    enc_count = '0;
  endfunction

  function automatic void put_result(logic [7:0] b, logic v, logic [ERR_W-1:0] e);
    if (item_nbytes < MAX_RESULTS) begin
      item_bytes[item_nbytes] = '{data: b, valid: v, last: 1'b0, err: e};
      item_nbytes++;
    end
  endfunction

  // held byte (plus carry), then the pending run as 0xff or 0x00
  function automatic void flush_held(logic carry);
    put_result(enc_held + {7'b0, carry}, 1'b1, ERR_OK);
    while (enc_pend > 0) begin
      put_result(carry ? 8'h00 : 8'hff, 1'b1, ERR_OK);
      enc_pend--;
    end
  endfunction

  // returns 1 when a pending byte was lost
  function automatic logic renormalize();
    logic ovf;
    ovf = 1'b0;
    for (int i = 0; i < 4 && enc_range <= BOTTOM_VAL; i++) begin
      if (enc_low < SETTLE_LIM) begin
        flush_held(1'b0);
        enc_held = enc_low[TOP_SHIFT +: 8];
      end else if (enc_low[CODE_W-1]) begin
        flush_held(1'b1);
        enc_held = enc_low[TOP_SHIFT +: 8];
      end else if (enc_pend < MAX_PENDING) begin
        enc_pend++;
      end else begin
        ovf = 1'b1;
      end
      enc_range = enc_range << 8;
      enc_low   = (enc_low << 8) & (TOP_VAL - 1);
      enc_count = enc_count + 1'b1;
    end
    return ovf;
  endfunction

  // advance the model by one accepted item and queue its results
  function automatic void encode_item(logic cmd, logic [15:0] clo, logic [15:0] chi,
                                      logic [15:0] tot);
    logic           ovf;
    logic [ERR_W-1:0] err;
    logic [9:0]     fin;
    logic [31:0]    r;
    logic [31:0]    part;
    item_nbytes = 0;
    err = ERR_OK;
    ovf = renormalize();
    if (cmd == CMD_FINISH) begin
      enc_count = enc_count + FINISH_ADD;
      fin = 10'(enc_low >> TOP_SHIFT);
      if ((enc_low & (BOTTOM_VAL - 1)) >= 32'(enc_count >> 1))
        fin = fin + 10'd1;
      if (fin > 10'hff)
        carry_flushes++;
      flush_held(fin > 10'hff);
      put_result(fin[7:0], 1'b1, ERR_OK);
      put_result(enc_count[23:16], 1'b1, ERR_OK);
      put_result(enc_count[15:8], 1'b1, ERR_OK);
      put_result(enc_count[7:0], 1'b1, ERR_OK);
      coder_restart();
      if (ovf)
        err = ERR_OVF;
    end else begin
      if (tot == 16'd0) begin
        err = ERR_ZERO;
      end else if (32'(tot) > (enc_range >> 1)) begin
        err = ERR_BIG;
      end else if (chi <= clo || chi > tot) begin
        err = ERR_EMPTY;
      end else begin
        r    = enc_range / 32'(tot);
        part = r * 32'(clo);
        enc_low = enc_low + part;
        if (chi < tot)
          enc_range = r * 32'(chi - clo);
        else
          enc_range = enc_range - part;
        if (ovf)
          err = ERR_OVF;
      end
    end
    if (err != ERR_OK) begin
      put_result(8'h00, 1'b0, err);
      error_reports++;
    end
    if (item_nbytes > 0)
      item_bytes[item_nbytes-1].last = 1'b1;
    for (int k = 0; k < item_nbytes; k++)
      expected_bytes.insert(expected_bytes.size(), item_bytes[k]);
  endfunction

  // Pick a symbol that keeps the interval across the carry point (the top
  // byte stays undecided, so the pending run grows), or one that lands just
  // above it so the next renormalization settles with a carry.
  function automatic void boundary_symbol(input logic go_above, output logic [15:0] clo,
                                          output logic [15:0] chi, output logic [15:0] tot);
    logic [31:0] sv_low, sv_range, lo, rg, r, gap, q;
    logic [7:0]  sv_held;
    logic [PEND_W-1:0] sv_pend;
    logic [COUNT_W-1:0] sv_count;
    logic [32:0] top;
    sv_low = enc_low; sv_range = enc_range; sv_held = enc_held;
    sv_pend = enc_pend; sv_count = enc_count;
    void'(renormalize());
    lo = enc_low;
    rg = enc_range;
    enc_low = sv_low; enc_range = sv_range; enc_held = sv_held;
    enc_pend = sv_pend; enc_count = sv_count;
    item_nbytes = 0;
    tot = 16'($urandom_range(65535, 4096));
    r = rg / 32'(tot);
    top = 33'(lo) + 33'(rg);
    if (lo[CODE_W-1] || top < 33'(TOP_VAL)) begin
      clo = 16'($urandom_range(32'(tot) - 1, 0));
    end else begin
      gap = TOP_VAL - 1 - lo;
      q = gap / r;
      if (go_above && ((gap + r) / r) < 32'(tot))
        q = (gap + r) / r;
      if (q > 32'(tot) - 1)
        q = 32'(tot) - 1;
      clo = q[15:0];
    end
    chi = clo + 16'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  coded_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_valid %0b error %0d last %0b",
               m_tdata, m_tuser[0], m_tuser[3:1], m_tlast);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.data) begin
          $error("out_byte mismatch: expected %0h, got %0h", want.data, m_tdata);
          mismatch_count++;
        end
        if (m_tuser[0] !== want.valid) begin
          $error("byte_valid mismatch: expected %0b, got %0b", want.valid, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tuser[3:1] !== want.err) begin
          $error("error mismatch: expected %0d, got %0d", want.err, m_tuser[3:1]);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    m_tready = ($urandom_range(99) >= snk_stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_range_encoder_byte_carry_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic set_idling(int src, int snk);
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // present one item from a falling edge, return at the falling edge after it
  task automatic send_item(logic cmd, logic [15:0] clo, logic [15:0] chi,
                           logic [15:0] tot);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid = 1'b1;
    s_tdata  = {tot, chi, clo};
    s_tuser  = cmd;
    do @(posedge clk); while (!s_tready);
    encode_item(cmd, clo, chi, tot);
    if (cmd == CMD_FINISH)
      finishes_sent++;
    else
      symbols_sent++;
    @(negedge clk);
  endtask

  task automatic send_boundary(logic go_above);
    logic [15:0] clo, chi, tot;
    boundary_symbol(go_above, clo, chi, tot);
    send_item(CMD_SYMBOL, clo, chi, tot);
  endtask

  task automatic test_field_extremes();
    set_idling(0, 0);
    send_item(CMD_SYMBOL, 16'd0, 16'hffff, 16'hffff);
    send_item(CMD_SYMBOL, 16'hfffe, 16'hffff, 16'hffff);
    send_item(CMD_SYMBOL, 16'd0, 16'd1, 16'd1);
    send_item(CMD_SYMBOL, 16'd0, 16'd1, 16'hffff);
    send_item(CMD_SYMBOL, 16'h7fff, 16'h8000, 16'h8000);
    send_item(CMD_FINISH, 16'hffff, 16'hffff, 16'hffff);
    // finish right after restart: header byte and a tiny trailer
    send_item(CMD_FINISH, 16'd0, 16'd0, 16'd0);
  endtask

  task automatic test_bad_symbols();
    set_idling(70, 0);
    send_item(CMD_SYMBOL, 16'hffff, 16'hffff, 16'd0);     // zero total
    send_item(CMD_SYMBOL, 16'd5, 16'd5, 16'd100);         // empty interval
    send_item(CMD_SYMBOL, 16'd9, 16'd3, 16'd100);         // reversed interval
    send_item(CMD_SYMBOL, 16'd0, 16'd101, 16'd100);       // beyond total
    send_item(CMD_SYMBOL, 16'hffff, 16'hffff, 16'hffff);
    send_item(CMD_SYMBOL, 16'd1, 16'd2, 16'hffff);
    send_item(CMD_SYMBOL, 16'd0, 16'd0, 16'd0);
    send_item(CMD_FINISH, 16'd0, 16'd0, 16'd0);
  endtask

  task automatic test_late_carry();
    set_idling(0, 70);
    repeat (4) send_boundary(1'b0);
    send_boundary(1'b1);
    send_item(CMD_SYMBOL, 16'd100, 16'd3000, 16'd4000);
    send_item(CMD_SYMBOL, 16'd0, 16'd1, 16'd60000);
    send_item(CMD_FINISH, 16'd0, 16'd0, 16'd0);
  endtask

  task automatic test_pending_overflow();
    set_idling(11, 11);
    // the run saturates after about 24 items; the rest lose bytes
    repeat (28) send_boundary(1'b0);
    send_item(CMD_SYMBOL, 16'd3, 16'd3, 16'd9);           // empty beats overflow
    send_boundary(1'b1);
    send_boundary(1'b0);
    send_item(CMD_FINISH, 16'd0, 16'd0, 16'd0);
    // again, but the finish itself overflows
    repeat (27) send_boundary(1'b0);
    send_item(CMD_FINISH, 16'hffff, 16'h0, 16'hffff);
  endtask

  task automatic random_item();
    int          sel;
    logic [15:0] clo, chi, tot;
    sel = $urandom_range(99);
    if (sel < 6) begin
      send_item(CMD_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 18) begin
      tot = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      send_item(CMD_SYMBOL, 16'($urandom), 16'($urandom), tot);
    end else if (sel < 32) begin
      send_boundary($urandom_range(5) == 0);
    end else begin
      if ($urandom_range(2) == 0)
        tot = 16'($urandom_range(16, 1));
      else
        tot = 16'($urandom_range(65535, 1));
      clo = 16'($urandom_range(32'(tot) - 1, 0));
      chi = 16'($urandom_range(32'(tot), 32'(clo) + 1));
      send_item(CMD_SYMBOL, clo, chi, tot);
    end
  endtask

  task automatic test_random_stream();
    set_idling(0, 0);
    repeat (20) random_item();
    set_idling(70, 0);
    repeat (20) random_item();
    set_idling(0, 70);
    repeat (20) random_item();
    set_idling(11, 11);
    repeat (20) random_item();
    send_item(CMD_FINISH, 16'd0, 16'd0, 16'd0);
  endtask

  initial begin
    coder_restart();
    item_nbytes = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_bad_symbols();
    test_late_carry();
    test_pending_overflow();
    test_random_stream();

    s_tvalid = 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d symbol items and %0d finish items, %0d results checked",
             symbols_sent, finishes_sent, results_checked);
    $display("error reports %0d, rounded final byte with carry %0d times",
             error_reports, carry_flushes);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("tb_range_encoder_byte_carry_unit passed");
    end else begin
      if (expected_bytes.size() != 0)
        $error("%0d expected results never arrived", expected_bytes.size());
      $display("tb_range_encoder_byte_carry_unit failed");
    end
    $finish;
  end

endmodule
